// ===== sv/dah_pkg.sv =====
// shared types, constants and angle tables for the distance and heading block
package dah_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int COORD_W = 26;
   localparam int MAG_W = 26;
   localparam int HEADING_W = 12;
   localparam int DIST_W = 27;
   localparam int CX_W = 62;
   localparam int Z_W = 64;
   localparam int SHIFT_IN = 32;
   localparam int QUO_W = 11;
   localparam int MM_W = 52;
   localparam int SUM_W = 53;
   localparam int ROOT_W = 55;
   localparam int ROOT_STEPS = 27;

   localparam int CORDIC_LAT = CORDIC_STAGES + 1;
   localparam int HDG_LAT = 2 + QUO_W;
   localparam int SQRT_LAT = 3 + ROOT_STEPS;
   localparam int BACK_LAT = CORDIC_LAT + HDG_LAT;
   localparam int DIST_DLY = BACK_LAT - SQRT_LAT;

   localparam logic signed [HEADING_W-1:0] HDG_NORTH = 12'sd0;
   localparam logic signed [HEADING_W-1:0] HDG_SOUTH = 12'sd1800;
   localparam logic signed [HEADING_W-1:0] HDG_EAST = -12'sd900;
   localparam logic signed [HEADING_W-1:0] HDG_WEST = 12'sd900;

   typedef struct packed {
      logic dx_zero;
      logic dz_zero;
      logic dx_pos;
      logic dz_neg;
   } dah_flags_type;

   typedef struct packed {
      logic [MAG_W-1:0] u;
      logic [MAG_W-1:0] v;
      dah_flags_type flags;
   } dah_item_type;

   typedef logic [63:0] atan_tab_type [CORDIC_STAGES];

   // pi in q60 by machin's formula, each series term truncated
   function automatic logic [63:0] calc_pi_q60();
      logic [63:0] p;
      logic [63:0] s5;
      logic [63:0] s239;
      logic [63:0] term;
      int k;
      s5 = 64'd0;
      p = (64'd1 << 60) / 64'd5;
      k = 0;
      while (p != 64'd0) begin
         term = p / 64'(2 * k + 1);
         if ((k % 2) == 1) s5 = s5 - term;
         else s5 = s5 + term;
         p = p / 64'd25;
         k = k + 1;
      end
      s239 = 64'd0;
      p = (64'd1 << 60) / 64'd239;
      k = 0;
      while (p != 64'd0) begin
         term = p / 64'(2 * k + 1);
         if ((k % 2) == 1) s239 = s239 - term;
         else s239 = s239 + term;
         p = p / 64'd57121;
         k = k + 1;
      end
      return 64'd16 * s5 - 64'd4 * s239;
   endfunction

   localparam logic [63:0] PI_Q60 = calc_pi_q60();
   localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
   localparam logic [63:0] PI_Q50 = PI_Q60 >> 10;
   localparam logic [63:0] TWO_PI_Q50 = PI_Q50 << 1;

   // atan(2^-i) in q60 by its taylor series, pi/4 for i = 0
   function automatic logic [63:0] calc_atan_q60(int i);
      logic [63:0] sum;
      logic [63:0] term;
      int k;
      int e;
      sum = 64'd0;
      if (i == 0) begin
         sum = PI_Q60 >> 2;
      end else begin
         for (k = 0; k <= 30; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
               term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
               if ((k % 2) == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic atan_tab_type calc_atan_tab();
      atan_tab_type t;
      for (int i = 0; i < CORDIC_STAGES; i++) t[i] = calc_atan_q60(i);
      return t;
   endfunction

   localparam atan_tab_type ATAN_Q60 = calc_atan_tab();

endpackage

// ===== sv/dah_front.sv =====
// front end: takes coordinate beats, forms offsets and flags, two-entry queue
module dah_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [dah_pkg::COORD_W-1:0] req_origin_x,
   input  logic signed [dah_pkg::COORD_W-1:0] req_origin_z,
   input  logic signed [dah_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [dah_pkg::COORD_W-1:0] req_target_z,
   input  logic                               pop,
   output logic                               item_valid,
   output dah_pkg::dah_item_type              item
);

   dah_pkg::dah_item_type q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic signed [26:0]    dx, dz;
   logic [26:0]           ax, az;
   dah_pkg::dah_item_type cls;
   logic                  push;

   always_comb begin
      dx = {req_target_x[25], req_target_x} - {req_origin_x[25], req_origin_x};
      dz = {req_target_z[25], req_target_z} - {req_origin_z[25], req_origin_z};
      ax = dx[26] ? 27'(-dx) : 27'(dx);
      az = dz[26] ? 27'(-dz) : 27'(dz);
      cls.u = ax[25:0];
      cls.v = az[25:0];
      cls.flags.dx_zero = (dx == 27'sd0);
      cls.flags.dz_zero = (dz == 27'sd0);
      cls.flags.dx_pos = !dx[26] && (dx != 27'sd0);
      cls.flags.dz_neg = dz[26];
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

endmodule

// ===== sv/dah_cordic.sv =====
// pipelined vectoring cordic, one micro-rotation per stage
module dah_cordic (
   input  logic                            clock,
   input  logic                            en,
   input  logic [dah_pkg::MAG_W-1:0]       u,
   input  logic [dah_pkg::MAG_W-1:0]       v,
   output logic signed [dah_pkg::Z_W-1:0]  angle
);

   logic signed [dah_pkg::CX_W-1:0] x_ff [dah_pkg::CORDIC_STAGES+1];
   logic signed [dah_pkg::CX_W-1:0] y_ff [dah_pkg::CORDIC_STAGES+1];
   logic signed [dah_pkg::Z_W-1:0]  z_ff [dah_pkg::CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= $signed({4'b0, v, {dah_pkg::SHIFT_IN{1'b0}}});
         y_ff[0] <= $signed({4'b0, u, {dah_pkg::SHIFT_IN{1'b0}}});
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < dah_pkg::CORDIC_STAGES; i++) begin : g_stage
      logic signed [dah_pkg::CX_W-1:0] xs, ys;
      logic signed [dah_pkg::Z_W-1:0]  at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = $signed(dah_pkg::ATAN_Q60[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end
         end
      end
   end

   assign angle = z_ff[dah_pkg::CORDIC_STAGES];

endmodule

// ===== sv/dah_heading.sv =====
// angle to tenths of a degree: clamp, fold, scale and restoring divide
module dah_heading (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [dah_pkg::Z_W-1:0] angle,
   input  logic                           south,
   output logic [dah_pkg::QUO_W-1:0]      tenths
);

   logic [63:0]                theta, m;
   logic [dah_pkg::MM_W-1:0]   mm_ff;
   logic [63:0]                n_ff;
   logic [63:0]                rem_ff [dah_pkg::QUO_W];
   logic [dah_pkg::QUO_W-1:0]  q_ff [dah_pkg::QUO_W];

   always_comb begin
      if (angle[63]) theta = 64'd0;
      else if (64'(angle) > dah_pkg::HALF_PI_Q60) theta = dah_pkg::HALF_PI_Q60;
      else theta = 64'(angle);
      m = south ? dah_pkg::PI_Q60 - theta : theta;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mm_ff <= m[61:10];
         n_ff <= 64'(mm_ff) * 64'd3600 + dah_pkg::PI_Q50;
      end
   end

   for (genvar j = 0; j < dah_pkg::QUO_W; j++) begin : g_div
      localparam int K = dah_pkg::QUO_W - 1 - j;
      localparam logic [63:0] DSH = dah_pkg::TWO_PI_Q50 << K;
      logic [63:0]               r_prev;
      logic [dah_pkg::QUO_W-1:0] q_prev;
      if (j == 0) begin : g_first
         assign r_prev = n_ff;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = rem_ff[j-1];
         assign q_prev = q_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (r_prev >= DSH) begin
               rem_ff[j] <= r_prev - DSH;
               q_ff[j] <= q_prev | (dah_pkg::QUO_W'(1) << K);
            end else begin
               rem_ff[j] <= r_prev;
               q_ff[j] <= q_prev;
            end
         end
      end
   end

   assign tenths = q_ff[dah_pkg::QUO_W-1];

endmodule

// ===== sv/dah_isqrt.sv =====
// pipelined rounded integer square root of u*u + v*v, one result bit per stage
module dah_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [dah_pkg::MAG_W-1:0]     u,
   input  logic [dah_pkg::MAG_W-1:0]     v,
   output logic [dah_pkg::DIST_W-1:0]    root
);

   logic [51:0]                 su_ff, sv_ff;
   logic [dah_pkg::SUM_W-1:0]   sum_ff;
   logic [dah_pkg::SUM_W-1:0]   s_ff [dah_pkg::ROOT_STEPS];
   logic [dah_pkg::ROOT_W-1:0]  r_ff [dah_pkg::ROOT_STEPS];
   logic [dah_pkg::DIST_W-1:0]  root_ff;
   logic [dah_pkg::ROOT_W-1:0]  r_last;

   always_ff @(posedge clock) begin
      if (en) begin
         su_ff <= 52'(u) * 52'(u);
         sv_ff <= 52'(v) * 52'(v);
         sum_ff <= 53'(su_ff) + 53'(sv_ff);
      end
   end

   for (genvar k = 0; k < dah_pkg::ROOT_STEPS; k++) begin : g_step
      localparam logic [dah_pkg::ROOT_W-1:0] BIT =
         dah_pkg::ROOT_W'(1) << (2 * (dah_pkg::ROOT_STEPS - 1 - k));
      logic [dah_pkg::SUM_W-1:0]  s_prev;
      logic [dah_pkg::ROOT_W-1:0] r_prev;
      logic [dah_pkg::ROOT_W-1:0] cand;
      if (k == 0) begin : g_first
         assign s_prev = sum_ff;
         assign r_prev = '0;
      end else begin : g_next
         assign s_prev = s_ff[k-1];
         assign r_prev = r_ff[k-1];
      end
      assign cand = r_prev + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (dah_pkg::ROOT_W'(s_prev) >= cand) begin
               s_ff[k] <= dah_pkg::SUM_W'(dah_pkg::ROOT_W'(s_prev) - cand);
               r_ff[k] <= (r_prev >> 1) + BIT;
            end else begin
               s_ff[k] <= s_prev;
               r_ff[k] <= r_prev >> 1;
            end
         end
      end
   end

   assign r_last = r_ff[dah_pkg::ROOT_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= dah_pkg::DIST_W'(r_last) +
                    dah_pkg::DIST_W'(dah_pkg::ROOT_W'(s_ff[dah_pkg::ROOT_STEPS-1]) > r_last);
      end
   end

   assign root = root_ff;

endmodule

// ===== sv/distance_and_heading.sv =====
// distance and heading: rounded range and -atan2(dx, dz) in tenths of a degree
// throughput: one beat per cycle unless the response stalls; set by the fully pipelined cordic, divider and root
// a full response register stalls the whole back pipeline; the two-entry front queue takes beats until full
// reset clears the queue, the stage valid bits and the response valid; no other state
module distance_and_heading (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dah_pkg::COORD_W-1:0]  req_origin_x,
   input  logic signed [dah_pkg::COORD_W-1:0]  req_origin_z,
   input  logic signed [dah_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [dah_pkg::COORD_W-1:0]  req_target_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dah_pkg::HEADING_W-1:0] rsp_heading_tenths,
   output logic [dah_pkg::DIST_W-1:0]          rsp_distance_blocks
);

   // front to back hand-off
   dah_pkg::dah_item_type item;
   logic                  item_valid;
   logic                  pop;
   logic                  adv;

   // back pipeline bookkeeping, one slot per stage
   logic                  vld_ff [dah_pkg::BACK_LAT];
   dah_pkg::dah_flags_type fl_ff [dah_pkg::BACK_LAT];
   logic [dah_pkg::DIST_W-1:0] dd_ff [dah_pkg::DIST_DLY];

   logic signed [dah_pkg::Z_W-1:0] angle;
   logic [dah_pkg::QUO_W-1:0]      tenths;
   logic [dah_pkg::DIST_W-1:0]     root_dist;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [dah_pkg::HEADING_W-1:0] heading_ff, heading_in;
   logic [dah_pkg::DIST_W-1:0]         distance_ff;
   dah_pkg::dah_flags_type             fl_out;
   logic signed [dah_pkg::HEADING_W-1:0] mag;

   // whole back end moves together whenever the response slot is free or draining
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && item_valid;

   dah_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_origin_x (req_origin_x),
      .req_origin_z (req_origin_z),
      .req_target_x (req_target_x),
      .req_target_z (req_target_z),
      .pop          (pop),
      .item_valid   (item_valid),
      .item         (item)
   );

   dah_cordic u_cordic (
      .clock (clock),
      .en    (adv),
      .u     (item.u),
      .v     (item.v),
      .angle (angle)
   );

   // south flag taken from the slot that lines up with the cordic output
   dah_heading u_heading (
      .clock  (clock),
      .en     (adv),
      .angle  (angle),
      .south  (fl_ff[dah_pkg::CORDIC_LAT-1].dz_neg),
      .tenths (tenths)
   );

   dah_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .u     (item.u),
      .v     (item.v),
      .root  (root_dist)
   );

   // valid bits: control, reset clears them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dah_pkg::BACK_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= pop;
         for (int i = 1; i < dah_pkg::BACK_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // flags and the early distance ride alongside the slow heading path
   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[0] <= item.flags;
         for (int i = 1; i < dah_pkg::BACK_LAT; i++) fl_ff[i] <= fl_ff[i-1];
         dd_ff[0] <= root_dist;
         for (int i = 1; i < dah_pkg::DIST_DLY; i++) dd_ff[i] <= dd_ff[i-1];
      end
   end

   // special directions override the cordic result
   always_comb begin
      fl_out = fl_ff[dah_pkg::BACK_LAT-1];
      mag = $signed(dah_pkg::HEADING_W'(tenths));
      if (fl_out.dx_zero) heading_in = fl_out.dz_neg ? dah_pkg::HDG_SOUTH : dah_pkg::HDG_NORTH;
      else if (fl_out.dz_zero) heading_in = fl_out.dx_pos ? dah_pkg::HDG_EAST : dah_pkg::HDG_WEST;
      else heading_in = fl_out.dx_pos ? -mag : mag;
      rsp_valid_in = adv ? vld_ff[dah_pkg::BACK_LAT-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   // response payload, held while the beat waits
   always_ff @(posedge clock) begin
      if (adv) begin
         heading_ff <= heading_in;
         distance_ff <= dd_ff[dah_pkg::DIST_DLY-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_heading_tenths = heading_ff;
   assign rsp_distance_blocks = distance_ff;

endmodule

// ===== test/tb_distance_and_heading.sv =====
// testbench for the distance and heading block: scoreboard-checked random and directed beats
`timescale 1ns / 100ps

module tb_distance_and_heading;

   localparam int N_RANDOM = 1300;
   localparam int STALL_LIMIT = 10000;
   localparam int DRAIN_CYCLES = 80;

   typedef logic signed [dah_pkg::COORD_W-1:0] coord_type;

   typedef struct {
      logic signed [dah_pkg::HEADING_W-1:0] heading;
      logic [dah_pkg::DIST_W-1:0] distance;
   } bearing_type;

   // bearing scoreboard: works out heading and range for each request beat
   class bearing_board;
      bearing_type awaited[$];
      int n_wrong;
      longint unsigned arc_tab[64];
      longint unsigned pi60;

      function longint unsigned inv_arctan(longint unsigned n);
         longint unsigned p, acc, t, k;
         p = (64'd1 << 60) / n;
         acc = 0;
         k = 0;
         while (p != 0) begin
            t = p / (2 * k + 1);
            if (k[0]) acc = acc - t;
            else acc = acc + t;
            p = p / (n * n);
            k++;
         end
         return acc;
      endfunction

      function new();
         longint unsigned acc, t, e;
         pi60 = 16 * inv_arctan(5) - 4 * inv_arctan(239);
         arc_tab[0] = pi60 >> 2;
         for (int i = 1; i < 64; i++) begin
            acc = 0;
            for (longint unsigned k = 0; k <= 60; k++) begin
               e = i * (2 * k + 1);
               if (e > 60) break;
               t = (64'd1 << (60 - e)) / (2 * k + 1);
               if (k[0]) acc = acc - t;
               else acc = acc + t;
            end
            arc_tab[i] = acc;
         end
         n_wrong = 0;
      endfunction

      // rounded integer square root, half away from zero
      function longint unsigned root_rounded(longint unsigned s);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         if (s > r) r++;
         return r;
      endfunction

      // first-quadrant angle magnitude in tenths, folded for southerly headings
      function longint unsigned tenths_mag(longint unsigned u, longint unsigned v, bit south);
         longint signed x, y, z, xs, ys;
         longint unsigned th, m, mm, pp;
         x = longint'(v << 32);
         y = longint'(u << 32);
         z = 0;
         for (int i = 0; i < dah_pkg::CORDIC_STAGES && i < 64; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(arc_tab[i]);
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(arc_tab[i]);
            end
         end
         if (z < 0) z = 0;
         th = longint'(z);
         if (th > (pi60 >> 1)) th = pi60 >> 1;
         m = south ? pi60 - th : th;
         mm = m >> 10;
         pp = pi60 >> 10;
         return (2 * mm * 1800 + pp) / (2 * pp);
      endfunction

      function void note(coord_type ox, coord_type oz, coord_type tx, coord_type tz);
         longint signed dx, dz, hd;
         longint unsigned u, v;
         bearing_type b;
         dx = longint'(tx) - longint'(ox);
         dz = longint'(tz) - longint'(oz);
         u = dx < 0 ? -dx : dx;
         v = dz < 0 ? -dz : dz;
         if (dx == 0) hd = (dz < 0) ? 1800 : 0;
         else if (dz == 0) hd = (dx > 0) ? -900 : 900;
         else begin
            hd = longint'(tenths_mag(u, v, dz < 0));
            if (dx > 0) hd = -hd;
         end
         b.heading = hd[dah_pkg::HEADING_W-1:0];
         b.distance = dah_pkg::DIST_W'(root_rounded(u * u + v * v));
         awaited.push_back(b);
      endfunction

      function void check(logic signed [dah_pkg::HEADING_W-1:0] hd,
                          logic [dah_pkg::DIST_W-1:0] dist_val);
         bearing_type b;
         if (awaited.size() == 0) begin
            n_wrong++;
            if (n_wrong <= 10) $display("unexpected response beat: heading %0d distance %0d",
                                        hd, dist_val);
            return;
         end
         b = awaited.pop_front();
         if (hd !== b.heading || dist_val !== b.distance) begin
            n_wrong++;
            if (n_wrong <= 10)
               $display("wrong response: heading %0d/%0d distance %0d/%0d (expected/actual)",
                        b.heading, hd, b.distance, dist_val);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   coord_type req_origin_x, req_origin_z, req_target_x, req_target_z;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [dah_pkg::HEADING_W-1:0] rsp_heading_tenths;
   logic [dah_pkg::DIST_W-1:0] rsp_distance_blocks;

   bearing_board board;
   bit calm;          // no idling on either side while set
   int quiet_cycles;

   distance_and_heading dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_origin_x(req_origin_x),
      .req_origin_z(req_origin_z),
      .req_target_x(req_target_x),
      .req_target_z(req_target_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_heading_tenths(rsp_heading_tenths),
      .rsp_distance_blocks(rsp_distance_blocks)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // drive one request beat from the falling edge and hold it until taken
   task automatic send_beat(coord_type ox, coord_type oz, coord_type tx, coord_type tz);
      while (!calm && $urandom_range(0, 99) < 16) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_origin_x <= ox;
      req_origin_z <= oz;
      req_target_x <= tx;
      req_target_z <= tz;
      do @(posedge clock); while (!req_ready);
      board.note(ox, oz, tx, tz);
   endtask

   function automatic coord_type in_range();
      return coord_type'(int'($urandom_range(0, 60000000)) - 30000000);
   endfunction

   // random beat: mostly in-range points, some raw 26-bit patterns, near-axis offsets
   task automatic send_random();
      coord_type ox, oz, tx, tz;
      int kind;
      kind = $urandom_range(0, 9);
      ox = in_range();
      oz = in_range();
      tx = in_range();
      tz = in_range();
      case (kind)
         0: begin
            ox = coord_type'($urandom);
            oz = coord_type'($urandom);
            tx = coord_type'($urandom);
            tz = coord_type'($urandom);
         end
         1: begin
            tx = ox + coord_type'(int'($urandom_range(0, 8)) - 4);
            tz = oz + coord_type'(int'($urandom_range(0, 8)) - 4);
         end
         2: tx = ox;
         3: tz = oz;
         4: tx = ox + coord_type'(int'($urandom_range(0, 2000)) - 1000);
         default: ;
      endcase
      send_beat(ox, oz, tx, tz);
   endtask

   // wait until every expected response has come back
   task automatic wait_drained();
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   // response side: ready drops at random outside the calm stretch
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check(rsp_heading_tenths, rsp_distance_blocks);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("distance_and_heading: mismatch");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_origin_x = '0;
      req_origin_z = '0;
      req_target_x = '0;
      req_target_z = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero offset, compass points, near due south, extremes
      send_beat(26'sd5, 26'sd7, 26'sd5, 26'sd7);
      send_beat(26'sd0, 26'sd0, 26'sd0, 26'sd100);
      send_beat(26'sd0, 26'sd0, 26'sd0, -26'sd100);
      send_beat(26'sd0, 26'sd0, 26'sd100, 26'sd0);
      send_beat(26'sd0, 26'sd0, -26'sd100, 26'sd0);
      send_beat(26'sd0, 26'sd0, 26'sd1, -26'sd30000000);
      send_beat(26'sd0, 26'sd0, -26'sd1, -26'sd30000000);
      send_beat(26'sd0, 26'sd0, 26'sd1, 26'sd30000000);
      send_beat(-26'sd30000000, -26'sd30000000, 26'sd30000000, 26'sd30000000);
      send_beat(26'sd30000000, 26'sd30000000, -26'sd30000000, -26'sd30000000);
      send_beat(26'sd30000000, -26'sd30000000, -26'sd30000000, 26'sd30000000);
      send_beat(-26'sd33554431 - 26'sd1, -26'sd33554431 - 26'sd1,
                26'sd33554431, 26'sd33554431);
      send_beat(26'sd33554431, 26'sd33554431,
                -26'sd33554431 - 26'sd1, -26'sd33554431 - 26'sd1);
      send_beat(26'sd0, 26'sd0, 26'sd3, 26'sd4);
      send_beat(26'sd0, 26'sd0, 26'sd1, 26'sd1);
      send_beat(26'sd0, 26'sd0, -26'sd1, -26'sd1);
      send_beat(26'sd0, 26'sd0, 26'sd1, 26'sd2);
      send_beat(26'sd0, 26'sd0, 26'sd30000000, -26'sd1);

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 400 && n < 650);
         if (n == 800) begin
            // hold off until every result so far is back
            @(negedge clock);
            req_valid <= 1'b0;
            wait_drained();
         end
         send_random();
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.n_wrong == 0 && board.awaited.size() == 0)
         $display("distance_and_heading: match");
      else
         $display("distance_and_heading: mismatch");
      $finish;
   end

endmodule
